[hdl/rv64i_integer_execute_defines.svh]
// Assertion macros for the integer execute block.
`ifndef RV64I_INTEGER_EXECUTE_DEFINES_SVH
`define RV64I_INTEGER_EXECUTE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define RVIE_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rvie assertion failed: same-cycle implication");

// Next-cycle implication.
`define RVIE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rvie assertion failed: next-cycle implication");

`else

`define RVIE_ASSERT_IMPLY(label, ck, rn, ante, cons)
`define RVIE_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

[hdl/rvie_pkg.sv]
package rvie_pkg;

    localparam int XLEN      = 64;
    localparam int IMM_W     = 32;
    localparam int FUNC_W    = 6;
    localparam int REG_IDX_W = 5;
    localparam int NUM_REGS  = 32;
    localparam int INSN_BYTES = 4;

    typedef logic [XLEN-1:0]      xword_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD   = 6'd0,
        FN_SUB   = 6'd1,
        FN_AND   = 6'd2,
        FN_XOR   = 6'd3,
        FN_OR    = 6'd4,
        FN_SLTU  = 6'd5,
        FN_SLT   = 6'd6,
        FN_ADDW  = 6'd7,
        FN_SUBW  = 6'd8,
        FN_SLL   = 6'd9,
        FN_SRL   = 6'd10,
        FN_SRA   = 6'd11,
        FN_SLLW  = 6'd12,
        FN_SRLW  = 6'd13,
        FN_SRAW  = 6'd14,
        FN_ADDI  = 6'd15,
        FN_ANDI  = 6'd16,
        FN_ORI   = 6'd17,
        FN_XORI  = 6'd18,
        FN_SLTIU = 6'd19,
        FN_SLTI  = 6'd20,
        FN_LUI   = 6'd21,
        FN_AUIPC = 6'd22,
        FN_ADDIW = 6'd23,
        FN_SLLI  = 6'd24,
        FN_SRLI  = 6'd25,
        FN_SRAI  = 6'd26,
        FN_SLLIW = 6'd27,
        FN_SRLIW = 6'd28,
        FN_SRAIW = 6'd29,
        FN_JAL   = 6'd30,
        FN_JALR  = 6'd31,
        FN_BEQ   = 6'd32,
        FN_BNE   = 6'd33,
        FN_BLT   = 6'd34,
        FN_BLTU  = 6'd35,
        FN_BGE   = 6'd36,
        FN_BGEU  = 6'd37
    } func_t;

    function automatic xword_t sext32(input logic [31:0] v);
        return {{(XLEN-32){v[31]}}, v};
    endfunction

endpackage

[hdl/rvie_instr_if.sv]
interface rvie_instr_if
    import rvie_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [REG_IDX_W-1:0]    rd_index;
    logic [REG_IDX_W-1:0]    rs1_index;
    logic [REG_IDX_W-1:0]    rs2_index;
    logic signed [IMM_W-1:0] imm;

    modport source (output valid, func, rd_index, rs1_index, rs2_index, imm, input ready);
    modport sink   (input valid, func, rd_index, rs1_index, rs2_index, imm, output ready);
endinterface

[hdl/rvie_result_if.sv]
interface rvie_result_if
    import rvie_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] result_value;
    logic [XLEN-1:0] next_pc;
    logic            wrote_register;
    logic            branch_taken;

    modport source (output valid, result_value, next_pc, wrote_register, branch_taken,
                    input ready);
    modport sink   (input valid, result_value, next_pc, wrote_register, branch_taken,
                    output ready);
endinterface

[hdl/rv64i_integer_execute.sv]
// RV64I integer execute block. Sustains one instruction per cycle while the result side
// takes its beats; each instruction beat yields one result beat: accepting the instruction
// registers the register file read together with it in the execute stage, and execute then
// loads the output register when it is free or being taken. The register file is a
// 32 x 64 synchronous memory read at accept time; the write-back of the instruction ahead
// lands at that same edge and is forwarded into execute, so dependent instructions run
// back to back. Per-entry valid bits make the file read as zero after reset with no
// clearing pass; x0 is never written and always reads zero. The program counter is a
// register owned by the execute stage. Writing start_address loads the counter directly;
// do it only while no instruction is in flight. The output register lets the next
// instruction enter while a result beat waits to be taken.
`include "rv64i_integer_execute_defines.svh"

module rv64i_integer_execute
    import rvie_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start_address_we,
    input  logic [XLEN-1:0] start_address,
    rvie_instr_if.sink      instr,
    rvie_result_if.source   result
);

    // register file memory and per-entry valid bits
    xword_t               rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0]  rf_vld_reg;

    // execute stage
    logic                 e_valid_reg;
    logic [FUNC_W-1:0]    e_func_reg;
    reg_idx_t             e_rd_reg;
    reg_idx_t             e_rs1_reg;
    reg_idx_t             e_rs2_reg;
    logic [IMM_W-1:0]     e_imm_reg;
    xword_t               a_mem_reg;
    xword_t               b_mem_reg;
    logic                 a_vld_reg;
    logic                 b_vld_reg;

    // write-back that landed at the same edge as the operand read
    logic                 fwd_valid_reg;
    reg_idx_t             fwd_idx_reg;
    xword_t               fwd_val_reg;

    xword_t               pc_reg;

    // output register
    logic                 out_valid_reg;
    xword_t               out_value_reg;
    xword_t               out_npc_reg;
    logic                 out_wrote_reg;
    logic                 out_taken_reg;

    logic                 e_adv;
    logic                 in_acc;
    logic                 wr_en;
    xword_t               op_a;
    xword_t               op_b;
    xword_t               imm64;
    xword_t               seq_pc;
    xword_t               val;
    xword_t               npc;
    logic                 wr_req;
    logic                 taken;
    logic [31:0]          w32;

    assign e_adv        = e_valid_reg && (!out_valid_reg || result.ready);
    assign in_acc       = instr.valid && instr.ready;
    assign instr.ready  = !e_valid_reg || e_adv;

    assign op_a = (fwd_valid_reg && fwd_idx_reg == e_rs1_reg) ? fwd_val_reg :
                  (a_vld_reg ? a_mem_reg : '0);
    assign op_b = (fwd_valid_reg && fwd_idx_reg == e_rs2_reg) ? fwd_val_reg :
                  (b_vld_reg ? b_mem_reg : '0);
    assign imm64  = sext32(e_imm_reg);
    assign seq_pc = pc_reg + XLEN'(INSN_BYTES);

    always_comb
    begin
        val    = '0;
        npc    = seq_pc;
        wr_req = 1'b1;
        taken  = 1'b0;
        w32    = '0;
        case (func_t'(e_func_reg))
            FN_ADD:   val = op_a + op_b;
            FN_SUB:   val = op_a - op_b;
            FN_AND:   val = op_a & op_b;
            FN_XOR:   val = op_a ^ op_b;
            FN_OR:    val = op_a | op_b;
            FN_SLTU:  val = {{(XLEN-1){1'b0}}, op_a < op_b};
            FN_SLT:   val = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(op_b)};
            FN_ADDW:
            begin
                w32 = op_a[31:0] + op_b[31:0];
                val = sext32(w32);
            end
            FN_SUBW:
            begin
                w32 = op_a[31:0] - op_b[31:0];
                val = sext32(w32);
            end
            FN_SLL:   val = op_a << op_b[5:0];
            FN_SRL:   val = op_a >> op_b[5:0];
            FN_SRA:   val = $unsigned($signed(op_a) >>> op_b[5:0]);
            FN_SLLW:
            begin
                w32 = op_a[31:0] << op_b[4:0];
                val = sext32(w32);
            end
            FN_SRLW:
            begin
                w32 = op_a[31:0] >> op_b[4:0];
                val = sext32(w32);
            end
            FN_SRAW:
            begin
                w32 = $unsigned($signed(op_a[31:0]) >>> op_b[4:0]);
                val = sext32(w32);
            end
            FN_ADDI:  val = op_a + imm64;
            FN_ANDI:  val = op_a & imm64;
            FN_ORI:   val = op_a | imm64;
            FN_XORI:  val = op_a ^ imm64;
            FN_SLTIU: val = {{(XLEN-1){1'b0}}, op_a < imm64};
            FN_SLTI:  val = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(imm64)};
            FN_LUI:   val = imm64;
            FN_AUIPC: val = pc_reg + imm64;
            FN_ADDIW:
            begin
                w32 = op_a[31:0] + e_imm_reg;
                val = sext32(w32);
            end
            FN_SLLI:  val = op_a << e_imm_reg[5:0];
            FN_SRLI:  val = op_a >> e_imm_reg[5:0];
            FN_SRAI:  val = $unsigned($signed(op_a) >>> e_imm_reg[5:0]);
            FN_SLLIW:
            begin
                w32 = op_a[31:0] << e_imm_reg[4:0];
                val = sext32(w32);
            end
            FN_SRLIW:
            begin
                w32 = op_a[31:0] >> e_imm_reg[4:0];
                val = sext32(w32);
            end
            FN_SRAIW:
            begin
                w32 = $unsigned($signed(op_a[31:0]) >>> e_imm_reg[4:0]);
                val = sext32(w32);
            end
            FN_JAL:
            begin
                val   = seq_pc;
                npc   = pc_reg + imm64;
                taken = 1'b1;
            end
            FN_JALR:
            begin
                // target from rs1 as read, before the link write
                val   = seq_pc;
                npc   = (op_a + imm64) & ~XLEN'(1);
                taken = 1'b1;
            end
            FN_BEQ, FN_BNE, FN_BLT, FN_BLTU, FN_BGE, FN_BGEU:
            begin
                wr_req = 1'b0;
                case (func_t'(e_func_reg))
                    FN_BEQ:  taken = (op_a == op_b);
                    FN_BNE:  taken = (op_a != op_b);
                    FN_BLT:  taken = ($signed(op_a) < $signed(op_b));
                    FN_BLTU: taken = (op_a < op_b);
                    FN_BGE:  taken = !($signed(op_a) < $signed(op_b));
                    default: taken = (op_a >= op_b);
                endcase
                if (taken)
                begin
                    npc = pc_reg + imm64;
                end
            end
            default:  wr_req = 1'b0;   // unassigned codes run as no-ops
        endcase
    end

    assign wr_en = e_adv && wr_req && (e_rd_reg != '0);

    // memory: write-back and registered operand read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[e_rd_reg] <= val;
        end
        if (in_acc)
        begin
            a_mem_reg <= rf_mem[instr.rs1_index];
            b_mem_reg <= rf_mem[instr.rs2_index];
        end
    end

    // execute payload, forwarding payload, output payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            e_func_reg  <= instr.func;
            e_rd_reg    <= instr.rd_index;
            e_rs1_reg   <= instr.rs1_index;
            e_rs2_reg   <= instr.rs2_index;
            e_imm_reg   <= instr.imm;
            a_vld_reg   <= rf_vld_reg[instr.rs1_index];
            b_vld_reg   <= rf_vld_reg[instr.rs2_index];
            fwd_idx_reg <= e_rd_reg;
            fwd_val_reg <= val;
        end
        if (e_adv)
        begin
            out_value_reg <= (wr_req && e_rd_reg != '0) ? val : '0;
            out_npc_reg   <= npc;
            out_wrote_reg <= wr_req && (e_rd_reg != '0);
            out_taken_reg <= taken;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg    <= '0;
            e_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                rf_vld_reg[e_rd_reg] <= 1'b1;
            end
            if (in_acc)
            begin
                fwd_valid_reg <= wr_en;
            end
            if (in_acc)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_adv)
            begin
                e_valid_reg <= 1'b0;
            end
            if (e_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (start_address_we)
            begin
                pc_reg <= start_address;
            end
            else if (e_adv)
            begin
                pc_reg <= npc;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_value   = out_value_reg;
    assign result.next_pc        = out_npc_reg;
    assign result.wrote_register = out_wrote_reg;
    assign result.branch_taken   = out_taken_reg;

    // counter follows the retired instruction's next PC
    `RVIE_ASSERT_NEXT(a_pc_follows, clk, rst_n, e_adv && !start_address_we, pc_reg == out_npc_reg)
    // a stalled execute stage keeps its instruction
    `RVIE_ASSERT_NEXT(a_e_holds, clk, rst_n, e_valid_reg && !e_adv, e_valid_reg)
    // no write reported means zero value
    `RVIE_ASSERT_IMPLY(a_nowrite_zero, clk, rst_n, out_valid_reg && !out_wrote_reg, out_value_reg == '0)
    // x0 never becomes valid in the file
    `RVIE_ASSERT_NEXT(a_x0_clear, clk, rst_n, e_adv, !rf_vld_reg[0])

endmodule
